// File: design/wts_pkg.sv
// Shared types, register map and reset constants of the wake trigger sequencer.
package wts_pkg;

    // Field widths
    localparam int MV_W   = 14;
    localparam int MS_W   = 16;
    localparam int MODE_W = 2;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    // Default timer width
    localparam int TIMER_WIDTH_DEF = 16;

    // Register indexes (byte address is 4 * index)
    localparam logic [IDX_W-1:0] REG_CHARGE_THRESH = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRESS_LEVEL   = 3'd1;
    localparam logic [IDX_W-1:0] REG_PULSE         = 3'd2;
    localparam logic [IDX_W-1:0] REG_STARTUP_WAIT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE      = 3'd4;
    localparam logic [IDX_W-1:0] REG_HOLD          = 3'd5;
    localparam logic [IDX_W-1:0] REG_PERMANENT     = 3'd6;

    // Register reset values
    localparam logic [MV_W-1:0] RST_CHARGE_THRESH = 14'd5000;
    localparam logic [MV_W-1:0] RST_PRESS_LEVEL   = 14'd1000;
    localparam logic [MS_W-1:0] RST_PULSE         = 16'd100;
    localparam logic [MS_W-1:0] RST_STARTUP_WAIT  = 16'd3000;
    localparam logic [MS_W-1:0] RST_DEBOUNCE      = 16'd50;
    localparam logic [MS_W-1:0] RST_HOLD          = 16'd500;
    localparam logic            RST_PERMANENT     = 1'b0;

    // An interval up to this length adds no wait phase
    localparam logic [MS_W-1:0] MIN_WAIT = 16'd1;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_STARTUP   = 4'd0,
        PH_CHARGE    = 4'd1,
        PH_DISCHARGE = 4'd2,
        PH_PERMANENT = 4'd3,
        PH_IDLE      = 4'd4,
        PH_BTN1      = 4'd5,
        PH_BTN2      = 4'd6,
        PH_PULSE     = 4'd7,
        PH_WAIT_DEB  = 4'd8,
        PH_WAIT_HOLD = 4'd9,
        PH_START     = 4'd10
    } t_phase;

    // Operating modes
    typedef enum logic [MODE_W-1:0] {
        MODE_NONE      = 2'd0,
        MODE_CHARGE    = 2'd1,
        MODE_DISCHARGE = 2'd2,
        MODE_PERMANENT = 2'd3
    } t_mode;

    // Configuration register set
    typedef struct packed {
        logic [MV_W-1:0] charge_thresh_mv;
        logic [MV_W-1:0] press_level_mv;
        logic [MS_W-1:0] pulse_ms;
        logic [MS_W-1:0] startup_wait_ms;
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] hold_ms;
        logic            permanent_mode;
    } t_cfg;

    // One result beat
    typedef struct packed {
        logic  pd12v_on;
        logic  pd0v_on;
        logic  pubat_on;
        logic  keepalive_en;
        t_mode mode_now;
    } t_result;

endpackage

// File: design/wts_cfg_regs.sv
// APB configuration register file of the wake trigger sequencer.
module wts_cfg_regs
    import wts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg             r_cfg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[ADDR_W-1:2];

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.charge_thresh_mv <= RST_CHARGE_THRESH;
            r_cfg.press_level_mv   <= RST_PRESS_LEVEL;
            r_cfg.pulse_ms         <= RST_PULSE;
            r_cfg.startup_wait_ms  <= RST_STARTUP_WAIT;
            r_cfg.debounce_ms      <= RST_DEBOUNCE;
            r_cfg.hold_ms          <= RST_HOLD;
            r_cfg.permanent_mode   <= RST_PERMANENT;
        end else if (wr_en) begin
            case (idx)
                REG_CHARGE_THRESH: r_cfg.charge_thresh_mv <= pwdata[MV_W-1:0];
                REG_PRESS_LEVEL:   r_cfg.press_level_mv   <= pwdata[MV_W-1:0];
                REG_PULSE:         r_cfg.pulse_ms         <= pwdata[MS_W-1:0];
                REG_STARTUP_WAIT:  r_cfg.startup_wait_ms  <= pwdata[MS_W-1:0];
                REG_DEBOUNCE:      r_cfg.debounce_ms      <= pwdata[MS_W-1:0];
                REG_HOLD:          r_cfg.hold_ms          <= pwdata[MS_W-1:0];
                REG_PERMANENT:     r_cfg.permanent_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (idx)
            REG_CHARGE_THRESH: prdata = DATA_W'(r_cfg.charge_thresh_mv);
            REG_PRESS_LEVEL:   prdata = DATA_W'(r_cfg.press_level_mv);
            REG_PULSE:         prdata = DATA_W'(r_cfg.pulse_ms);
            REG_STARTUP_WAIT:  prdata = DATA_W'(r_cfg.startup_wait_ms);
            REG_DEBOUNCE:      prdata = DATA_W'(r_cfg.debounce_ms);
            REG_HOLD:          prdata = DATA_W'(r_cfg.hold_ms);
            REG_PERMANENT:     prdata = DATA_W'(r_cfg.permanent_mode);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/wts_core.sv
// Phase sequencer: timers, mode and wake line state, one tick per step.
module wts_core
    import wts_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [MV_W-1:0] i_mv,
    input  logic            i_can,
    input  t_cfg            i_cfg,
    output t_result         o_next
);

    localparam int CMP_W = (TIMER_WIDTH > MS_W) ? TIMER_WIDTH : MS_W;
    localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

    t_phase                 r_phase, n_phase;
    t_phase                 r_resume, n_resume;
    logic [TIMER_WIDTH-1:0] r_tick, n_tick;
    t_mode                  r_mode, n_mode;
    logic                   r_pd12v, n_pd12v;
    logic                   r_pd0v, n_pd0v;
    logic                   r_pubat, n_pubat;
    logic                   r_keep, n_keep;

    logic                   pressed, released;
    logic [TIMER_WIDTH-1:0] tick_inc;
    logic                   tick_sat, inc_sat;
    logic                   start_expired;
    logic                   pulse_done, deb_done, hold_done;
    logic                   deb_short, hold_short;
    logic                   fire;
    t_phase                 idle_next;

    // Button sense and timer compares
    assign pressed   = i_mv < i_cfg.press_level_mv;
    assign released  = i_mv > i_cfg.press_level_mv;
    assign tick_sat  = (r_tick == TMAX);
    assign tick_inc  = tick_sat ? r_tick : r_tick + 1'b1;
    assign inc_sat   = (tick_inc == TMAX);

    assign start_expired = (CMP_W'(r_tick) >= CMP_W'(i_cfg.startup_wait_ms)) || tick_sat;
    assign pulse_done    = (CMP_W'(tick_inc) >= CMP_W'(i_cfg.pulse_ms)) || inc_sat;
    // A zero interval written mid-wait only ends on saturation
    assign deb_done  = inc_sat || ((i_cfg.debounce_ms != '0) &&
                       (CMP_W'(tick_inc) >= CMP_W'(i_cfg.debounce_ms - 1'b1)));
    assign hold_done = inc_sat || ((i_cfg.hold_ms != '0) &&
                       (CMP_W'(tick_inc) >= CMP_W'(i_cfg.hold_ms - 1'b1)));
    assign deb_short  = i_cfg.debounce_ms <= MIN_WAIT;
    assign hold_short = i_cfg.hold_ms <= MIN_WAIT;
    assign idle_next  = pressed ? PH_BTN1 : PH_IDLE;

    // Ticks that fire a wake pulse
    assign fire = ((r_phase == PH_START) && i_cfg.permanent_mode) ||
                  (r_phase == PH_CHARGE) || (r_phase == PH_PERMANENT) ||
                  ((r_phase == PH_BTN2) && !pressed && (r_mode == MODE_CHARGE));

    // Next phase, resume phase and timer
    always_comb begin
        n_phase  = r_phase;
        n_resume = r_resume;
        n_tick   = r_tick;
        case (r_phase)
            PH_START: begin
                if (i_cfg.permanent_mode) begin
                    n_phase = PH_PULSE;
                    n_tick  = '0;
                end else if (i_cfg.startup_wait_ms == '0) begin
                    n_phase = PH_CHARGE;
                    n_tick  = '0;
                end else if (i_can) begin
                    n_phase = PH_DISCHARGE;
                    n_tick  = '0;
                end else begin
                    n_phase = PH_STARTUP;
                    n_tick  = TIMER_WIDTH'(1);
                end
            end
            PH_STARTUP: begin
                if (start_expired) begin
                    n_phase = PH_CHARGE;
                    n_tick  = '0;
                end else if (i_can) begin
                    n_phase = PH_DISCHARGE;
                    n_tick  = '0;
                end else begin
                    n_tick  = r_tick + 1'b1;
                end
            end
            PH_CHARGE, PH_PERMANENT: begin
                n_phase = PH_PULSE;
                n_tick  = '0;
            end
            PH_DISCHARGE: begin
                if (released) begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            end
            PH_IDLE: begin
                n_tick = '0;
                if (deb_short) begin
                    n_phase  = idle_next;
                end else begin
                    n_resume = idle_next;
                    n_phase  = PH_WAIT_DEB;
                end
            end
            PH_BTN1: begin
                n_tick = '0;
                if (hold_short) begin
                    n_phase  = pressed ? PH_BTN2 : PH_IDLE;
                end else begin
                    n_resume = pressed ? PH_BTN2 : PH_IDLE;
                    n_phase  = PH_WAIT_HOLD;
                end
            end
            PH_BTN2: begin
                n_tick = '0;
                if (pressed) begin
                    if (hold_short) begin
                        n_phase  = PH_STARTUP;
                    end else begin
                        n_resume = PH_STARTUP;
                        n_phase  = PH_WAIT_HOLD;
                    end
                end else if (fire) begin
                    n_phase = PH_PULSE;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_PULSE: begin
                if (pulse_done) begin
                    n_phase = r_resume;
                    n_tick  = '0;
                end else begin
                    n_tick  = tick_inc;
                end
            end
            PH_WAIT_DEB: begin
                if (deb_done) begin
                    n_phase = r_resume;
                    n_tick  = '0;
                end else begin
                    n_tick  = tick_inc;
                end
            end
            PH_WAIT_HOLD: begin
                if (hold_done) begin
                    n_phase = r_resume;
                    n_tick  = '0;
                end else begin
                    n_tick  = tick_inc;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase
        // Every pulse returns to idle
        if (fire) begin
            n_resume = PH_IDLE;
        end
    end

    // Next mode, keepalive and line levels
    always_comb begin
        n_mode  = r_mode;
        n_keep  = r_keep;
        n_pd12v = r_pd12v;
        n_pd0v  = r_pd0v;
        n_pubat = r_pubat;
        case (r_phase)
            PH_START: begin
                if (i_cfg.permanent_mode) begin
                    n_mode = MODE_PERMANENT;
                    n_keep = 1'b1;
                end
            end
            PH_CHARGE:    n_mode = MODE_CHARGE;
            PH_DISCHARGE: begin
                n_mode = MODE_DISCHARGE;
                n_keep = 1'b1;
            end
            PH_PERMANENT: begin
                n_mode = MODE_PERMANENT;
                n_keep = 1'b1;
            end
            PH_BTN1: begin
                if (pressed) begin
                    n_pd12v = 1'b0;
                    n_pd0v  = 1'b0;
                    n_pubat = 1'b0;
                    n_keep  = 1'b0;
                    n_mode  = (r_mode != MODE_NONE) ? MODE_NONE : MODE_CHARGE;
                end
            end
            PH_PULSE: begin
                if (pulse_done) begin
                    n_pd0v = 1'b0;
                end
            end
            default: ;
        endcase
        // Wake pulse: deep pulse also holds PU_BAT
        if (fire) begin
            n_pd12v = 1'b1;
            n_pd0v  = 1'b1;
            if (!(i_mv > i_cfg.charge_thresh_mv)) begin
                n_pubat = 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_resume <= PH_IDLE;
            r_tick   <= '0;
            r_mode   <= MODE_NONE;
            r_pd12v  <= 1'b0;
            r_pd0v   <= 1'b0;
            r_pubat  <= 1'b0;
            r_keep   <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_resume <= n_resume;
            r_tick   <= n_tick;
            r_mode   <= n_mode;
            r_pd12v  <= n_pd12v;
            r_pd0v   <= n_pd0v;
            r_pubat  <= n_pubat;
            r_keep   <= n_keep;
        end
    end

    assign o_next.pd12v_on     = n_pd12v;
    assign o_next.pd0v_on      = n_pd0v;
    assign o_next.pubat_on     = n_pubat;
    assign o_next.keepalive_en = n_keep;
    assign o_next.mode_now     = n_mode;

`ifndef NO_ASSERTIONS
    // PD0V is high exactly while a pulse runs
    a_pd0v_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pd0v == (r_phase == PH_PULSE))
        else $error("PD0V level out of step with pulse phase");

    // PD0V never drives without PD12V
    a_pd0v_pd12v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pd0v |-> r_pd12v)
        else $error("PD0V driven without PD12V");

    // Discharge and permanent modes keep the keepalive running
    a_mode_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_PERMANENT || r_mode == MODE_DISCHARGE) |-> r_keep)
        else $error("keepalive off in a keepalive mode");
`endif

endmodule

// File: design/wake_trigger_sequencer.sv
// Top level of the wake trigger sequencer: handshake registers, config and core.
//
// One input beat is one 1 ms tick carrying the wake-detect voltage and the CAN
// flag; each beat yields one result beat with the wake line levels, the
// keepalive enable and the mode after that tick. The block takes one beat per
// clock cycle while results are taken; a result beat is valid once its tick has
// passed the input register and the result register: the tick sits in the input
// register while the single-pass phase update computes the levels, which load
// into the result register once it is free. A held result stalls input only once
// both registers are full. Registers are written over the APB port (pready always
// high) at byte address 4 * index; there is no clearing pass.
module wake_trigger_sequencer
    import wts_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [MV_W-1:0]   i_wake_mv,
    input  logic              i_can_seen,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_pd12v_on,
    output logic              o_pd0v_on,
    output logic              o_pubat_on,
    output logic              o_keepalive_en,
    output logic [MODE_W-1:0] o_mode_now,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg            cfg;
    t_result         core_next;
    logic            r_in_valid;
    logic [MV_W-1:0] r_in_mv;
    logic            r_in_can;
    logic            r_out_valid;
    t_result         r_out;
    logic            step;
    logic            in_take;

    wts_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wts_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_mv    (r_in_mv),
        .i_can   (r_in_can),
        .i_cfg   (cfg),
        .o_next  (core_next)
    );

    // Handshake: a beat moves on when the result register frees up
    assign step       = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | step;
    assign in_take    = i_in_valid & o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take | (r_in_valid & ~step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mv  <= i_wake_mv;
            r_in_can <= i_can_seen;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= step | (r_out_valid & ~i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pd12v_on     = r_out.pd12v_on;
    assign o_pd0v_on      = r_out.pd0v_on;
    assign o_pubat_on     = r_out.pubat_on;
    assign o_keepalive_en = r_out.keepalive_en;
    assign o_mode_now     = r_out.mode_now;

`ifndef NO_ASSERTIONS
    // A processed tick always shows up as a result beat
    a_step_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed tick produced no result beat");

    // An accepted beat lands in the input register
    a_take_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted beat lost");

    // A waiting beat holds its payload until it is processed
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_in_mv) && $stable(r_in_can)))
        else $error("waiting beat changed before processing");
`endif

endmodule

// File: dv/wake_trigger_sequencer_tb.sv
// Self-checking testbench of the wake trigger sequencer: tick stimulus, predictor, beat checks.
module wake_trigger_sequencer_tb;
    import wts_pkg::*;

    localparam int TMR_W = TIMER_WIDTH_DEF;
    localparam logic [TMR_W-1:0] TMR_MAX = '1;
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;   // beyond the register map
    localparam int CYCLE_LIMIT = 500000;
    localparam int CHOKE_AT = 400;
    localparam int CHOKE_LEN = 300;
    localparam int SETTLE = 8;

    // Directed ticks: permanent entry, pulse, long press, CAN, press-level edges
    localparam int DIR_N = 24;
    localparam int DIR_MV [DIR_N] = '{16383, 5000, 5001, 4999,
                                      0, 0, 0, 0, 0, 0, 0, 0,
                                      1000, 1000, 1001,
                                      999, 999, 999, 999, 999, 999,
                                      16383, 4999, 8191};
    localparam bit DIR_CAN [DIR_N] = '{0, 1, 0, 0,
                                      0, 0, 0, 0, 0, 0, 0, 1,
                                      1, 0, 0,
                                      0, 0, 0, 0, 0, 0,
                                      1, 0, 0};

    typedef struct packed {
        logic [MV_W-1:0] mv;
        logic            can;
    } tick_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_ready;
    logic [MV_W-1:0]   wake_mv = '0;
    logic              can_seen = 1'b0;
    logic              o_out_valid;
    logic              out_ready = 1'b0;
    logic              o_pd12v_on;
    logic              o_pd0v_on;
    logic              o_pubat_on;
    logic              o_keepalive_en;
    logic [MODE_W-1:0] o_mode_now;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    tick_t   tick_q[$];
    t_result level_q[$];
    int      ticks_taken = 0;
    int      beats_checked = 0;
    int      err_cnt = 0;
    int      cycle_cnt = 0;
    int      src_gap = 0;
    int      sink_gap = 0;
    bit      idle_on = 1'b0;
    logic    choke = 1'b0;

    // Predictor state and its copy of the registers
    t_cfg             live_cfg = '{RST_CHARGE_THRESH, RST_PRESS_LEVEL, RST_PULSE,
                                   RST_STARTUP_WAIT, RST_DEBOUNCE, RST_HOLD, RST_PERMANENT};
    t_phase           seq_ph = PH_START;
    t_phase           seq_resume = PH_IDLE;
    logic [TMR_W-1:0] seq_tick = '0;
    t_mode            seq_mode = MODE_NONE;
    logic             seq_pd12v = 1'b0;
    logic             seq_pd0v = 1'b0;
    logic             seq_pubat = 1'b0;
    logic             seq_keep = 1'b0;

    wake_trigger_sequencer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_wake_mv      (wake_mv),
        .i_can_seen     (can_seen),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_pd12v_on     (o_pd12v_on),
        .o_pd0v_on      (o_pd0v_on),
        .o_pubat_on     (o_pubat_on),
        .o_keepalive_en (o_keepalive_en),
        .o_mode_now     (o_mode_now),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void seq_goto(t_phase nxt);
        seq_ph = nxt;
        seq_tick = '0;
    endfunction

    // Step the tick timer; saturated counts as expired
    function automatic bit seq_count_done(logic [31:0] target);
        if (seq_tick != TMR_MAX)
            seq_tick = seq_tick + 1'b1;
        return (32'(seq_tick) >= target) || (seq_tick == TMR_MAX);
    endfunction

    function automatic void seq_act_wait(logic [MS_W-1:0] interval, t_phase wait_ph,
                                         t_phase nxt);
        if (interval <= MIN_WAIT) begin
            seq_goto(nxt);
        end else begin
            seq_resume = nxt;
            seq_goto(wait_ph);
        end
    endfunction

    // Charge pulse above threshold, deep pulse (PU_BAT too) otherwise
    function automatic void seq_fire(logic [MV_W-1:0] mv);
        seq_pd12v = 1'b1;
        seq_pd0v = 1'b1;
        if (!(mv > live_cfg.charge_thresh_mv))
            seq_pubat = 1'b1;
        seq_resume = PH_IDLE;
        seq_goto(PH_PULSE);
    endfunction

    function automatic void seq_startup(logic can);
        if (32'(seq_tick) >= 32'(live_cfg.startup_wait_ms) || seq_tick == TMR_MAX)
            seq_goto(PH_CHARGE);
        else if (can)
            seq_goto(PH_DISCHARGE);
        else
            seq_tick = seq_tick + 1'b1;
    endfunction

    function automatic void seq_permanent(logic [MV_W-1:0] mv);
        seq_mode = MODE_PERMANENT;
        seq_keep = 1'b1;
        seq_fire(mv);
    endfunction

    // One tick of the sequencer; returns the line levels after it
    function automatic t_result advance_wake_seq(logic [MV_W-1:0] mv, logic can);
        bit      pressed;
        bit      released;
        t_result r;
        pressed = mv < live_cfg.press_level_mv;
        released = mv > live_cfg.press_level_mv;
        case (seq_ph)
            PH_START: begin
                if (live_cfg.permanent_mode) begin
                    seq_permanent(mv);
                end else begin
                    seq_goto(PH_STARTUP);
                    seq_startup(can);
                end
            end
            PH_STARTUP: seq_startup(can);
            PH_CHARGE: begin
                seq_mode = MODE_CHARGE;
                seq_fire(mv);
            end
            PH_DISCHARGE: begin
                seq_mode = MODE_DISCHARGE;
                seq_keep = 1'b1;
                if (released)
                    seq_goto(PH_IDLE);
            end
            PH_PERMANENT: seq_permanent(mv);
            PH_IDLE: seq_act_wait(live_cfg.debounce_ms, PH_WAIT_DEB,
                                  pressed ? PH_BTN1 : PH_IDLE);
            PH_BTN1: begin
                if (pressed) begin
                    seq_pd12v = 1'b0;
                    seq_pd0v = 1'b0;
                    seq_pubat = 1'b0;
                    seq_keep = 1'b0;
                    seq_mode = (seq_mode != MODE_NONE) ? MODE_NONE : MODE_CHARGE;
                    seq_act_wait(live_cfg.hold_ms, PH_WAIT_HOLD, PH_BTN2);
                end else begin
                    seq_act_wait(live_cfg.hold_ms, PH_WAIT_HOLD, PH_IDLE);
                end
            end
            PH_BTN2: begin
                if (pressed)
                    seq_act_wait(live_cfg.hold_ms, PH_WAIT_HOLD, PH_STARTUP);
                else if (seq_mode == MODE_CHARGE)
                    seq_fire(mv);
                else
                    seq_goto(PH_IDLE);
            end
            PH_PULSE: begin
                if (seq_count_done(32'(live_cfg.pulse_ms))) begin
                    seq_pd0v = 1'b0;
                    seq_goto(seq_resume);
                end
            end
            PH_WAIT_DEB: begin
                if (seq_count_done(32'(live_cfg.debounce_ms) - 32'd1))
                    seq_goto(seq_resume);
            end
            PH_WAIT_HOLD: begin
                if (seq_count_done(32'(live_cfg.hold_ms) - 32'd1))
                    seq_goto(seq_resume);
            end
            default: seq_goto(PH_IDLE);
        endcase
        r.pd12v_on = seq_pd12v;
        r.pd0v_on = seq_pd0v;
        r.pubat_on = seq_pubat;
        r.keepalive_en = seq_keep;
        r.mode_now = seq_mode;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(string what, int got, int want);
        err_cnt++;
        $display("MISMATCH %s: got %0d, expected %0d (beat %0d)",
                 what, got, want, beats_checked);
    endtask

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Driver: offers pending ticks, predicts each accepted beat
    always @(posedge i_clk) begin : drive_ticks
        tick_t t;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                level_q.push_back(advance_wake_seq(wake_mv, can_seen));
                ticks_taken++;
            end
            if (!in_valid || o_in_ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    in_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 10);
                    in_valid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    t = tick_q.pop_front();
                    in_valid <= 1'b1;
                    wake_mv <= t.mv;
                    can_seen <= t.can;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, compares each result beat
    always @(posedge i_clk) begin : check_levels
        t_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                beats_checked++;
                if (level_q.size() == 0) begin
                    flag_mismatch("beat with nothing pending", 1, 0);
                end else begin
                    want = level_q.pop_front();
                    if (o_pd12v_on !== want.pd12v_on)
                        flag_mismatch("pd12v_on", o_pd12v_on, want.pd12v_on);
                    if (o_pd0v_on !== want.pd0v_on)
                        flag_mismatch("pd0v_on", o_pd0v_on, want.pd0v_on);
                    if (o_pubat_on !== want.pubat_on)
                        flag_mismatch("pubat_on", o_pubat_on, want.pubat_on);
                    if (o_keepalive_en !== want.keepalive_en)
                        flag_mismatch("keepalive_en", o_keepalive_en, want.keepalive_en);
                    if (o_mode_now !== want.mode_now)
                        flag_mismatch("mode_now", o_mode_now, want.mode_now);
                end
            end
            if (sink_gap != 0) begin
                sink_gap--;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(0, 10);
                out_ready <= 1'b0;
            end else begin
                out_ready <= !choke;
            end
        end
    end

    // Long receiver hold-off so the block fills and stalls its input
    initial begin
        wait (ticks_taken >= CHOKE_AT);
        @(posedge i_clk);
        choke <= 1'b1;
        repeat (CHOKE_LEN) @(posedge i_clk);
        choke <= 1'b0;
    end

    // ---------------------------------------------------------------- stimulus

    // APB write: setup then access; upper bits beyond the field carry noise
    task automatic reg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] mask;
        case (idx)
            REG_CHARGE_THRESH, REG_PRESS_LEVEL: mask = (32'd1 << MV_W) - 1;
            REG_PULSE, REG_STARTUP_WAIT, REG_DEBOUNCE, REG_HOLD: mask = (32'd1 << MS_W) - 1;
            REG_PERMANENT: mask = 32'd1;
            default: mask = '0;
        endcase
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= ($urandom() & ~mask) | (value & mask);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CHARGE_THRESH: live_cfg.charge_thresh_mv = value[MV_W-1:0];
            REG_PRESS_LEVEL:   live_cfg.press_level_mv = value[MV_W-1:0];
            REG_PULSE:         live_cfg.pulse_ms = value[MS_W-1:0];
            REG_STARTUP_WAIT:  live_cfg.startup_wait_ms = value[MS_W-1:0];
            REG_DEBOUNCE:      live_cfg.debounce_ms = value[MS_W-1:0];
            REG_HOLD:          live_cfg.hold_ms = value[MS_W-1:0];
            REG_PERMANENT:     live_cfg.permanent_mode = value[0];
            default: ;
        endcase
    endtask

    task automatic load_cfg(int thresh, int press, int pulse, int start_wait,
                            int deb, int hold, int perm);
        reg_write(REG_CHARGE_THRESH, thresh);
        reg_write(REG_PRESS_LEVEL, press);
        reg_write(REG_PULSE, pulse);
        reg_write(REG_STARTUP_WAIT, start_wait);
        reg_write(REG_DEBOUNCE, deb);
        reg_write(REG_HOLD, hold);
        reg_write(REG_PERMANENT, perm);
        reg_write(REG_SPARE, $urandom());
    endtask

    // Wait until every tick is taken and every beat checked, then settle
    task automatic drain_block();
        while (tick_q.size() != 0 || in_valid || level_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Runs of pressed and released voltages with rare CAN, plus some noise
    task automatic queue_random_ticks(int n);
        tick_t t;
        int    kind;
        int    run_len;
        int    press;
        int    thresh;
        kind = 0;
        run_len = 0;
        press = live_cfg.press_level_mv;
        thresh = live_cfg.charge_thresh_mv;
        @(negedge i_clk);
        repeat (n) begin
            if (run_len == 0) begin
                kind = $urandom_range(0, 9);
                run_len = $urandom_range(1, 25);
            end
            run_len--;
            t.can = ($urandom_range(0, 9) == 0);
            if (kind <= 3) begin
                t.mv = (press == 0) ? '0 : MV_W'($urandom_range(0, press - 1));
            end else if (kind <= 7) begin
                case ($urandom_range(0, 3))
                    0: t.mv = MV_W'(thresh);
                    1: t.mv = MV_W'(thresh + 1);
                    2: t.mv = '1;
                    default: t.mv = MV_W'($urandom_range(press, 16383));
                endcase
                if (int'(t.mv) <= press && press != 16383)
                    t.mv = MV_W'($urandom_range(press + 1, 16383));
            end else if (kind == 8) begin
                t.mv = MV_W'(press);
            end else begin
                t.mv = MV_W'($urandom());
                t.can = $urandom_range(0, 1);
            end
            tick_q.push_back(t);
        end
    endtask

    task automatic queue_released_ticks(int n);
        @(negedge i_clk);
        repeat (n) tick_q.push_back('{mv: '1, can: 1'b0});
    endtask

    initial begin
        int k;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: permanent entry on the first tick, short timers
        load_cfg(5000, 1000, 3, 4, 2, 3, 1);
        idle_on = 1'b0;
        @(negedge i_clk);
        for (k = 0; k < DIR_N; k++)
            tick_q.push_back('{mv: MV_W'(DIR_MV[k]), can: DIR_CAN[k]});
        drain_block();

        // Low extremes: zero thresholds and waits, unit pulse
        load_cfg(0, 0, 1, 0, 0, 0, 0);
        idle_on = 1'b1;
        queue_random_ticks(120);
        drain_block();

        // Top thresholds, unit waits and a short pulse
        load_cfg(16383, 16383, 2, 1, 1, 1, 1);
        queue_random_ticks(120);
        drain_block();

        // Longest intervals
        load_cfg($urandom_range(0, 16383), $urandom_range(0, 8000), 65535, 65535,
                 65535, 65535, 0);
        queue_random_ticks(60);
        drain_block();

        // Random short settings; some phases without idling
        for (k = 0; k < 6; k++) begin
            load_cfg($urandom_range(0, 16383), $urandom_range(0, 8000),
                     $urandom_range(1, 6), $urandom_range(0, 20),
                     $urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 1));
            idle_on = (k % 3 != 2);
            queue_random_ticks(120);
            drain_block();
        end

        // Park in a long debounce wait, then shrink its target below the count
        idle_on = 1'b0;
        load_cfg(5000, 1000, 1, 0, 40000, 1, 0);
        for (k = 0; k < 4 && seq_ph != PH_WAIT_DEB; k++) begin
            queue_released_ticks(12);
            drain_block();
        end
        load_cfg(5000, 1000, 1, 0, 3, 1, 0);
        queue_released_ticks(30);
        drain_block();

        // Closing random stretch with both sides always ready
        load_cfg($urandom_range(0, 16383), $urandom_range(0, 8000), $urandom_range(1, 6),
                 $urandom_range(0, 20), $urandom_range(0, 4), $urandom_range(0, 4), 0);
        queue_random_ticks(100);
        drain_block();

        if (level_q.size() != 0)
            flag_mismatch("beats never delivered", 0, level_q.size());
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
design/wts_pkg.sv
design/wts_cfg_regs.sv
design/wts_core.sv
design/wake_trigger_sequencer.sv
dv/wake_trigger_sequencer_tb.sv
